FILE: rtl/core/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, angle constants, arctangent table and square root step
// ----------------------------------------------------------------------------
package q2e_pkg;

	localparam int FRAC_Q     = 30;
	localparam int PROD_W     = 34;
	localparam int XY_W       = 40;
	localparam int Z_W        = 34;
	localparam int MAG_W      = 30;
	localparam int SQ_W       = 60;
	localparam int RAD_W      = 62;
	localparam int ROOT_W     = 31;
	localparam int REM_W      = 34;
	localparam int SQRT_STEPS = 31;

	localparam logic signed [XY_W-1:0] ONE_Q30     = 40'sd1073741824;
	localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;

	localparam logic [31:0] ATAN_TAB [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_acc_t;

	// one restoring digit of the integer square root
	function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] pair);
		logic [REM_W-1:0] r2;
		logic [REM_W-1:0] trial;
		sqrt_acc_t        o;
		r2    = {a.rem[REM_W-3:0], pair};
		trial = {1'b0, a.root, 2'b01};
		if (r2 >= trial) begin
			o.rem  = r2 - trial;
			o.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = r2;
			o.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

FILE: rtl/core/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic atan2, one iteration per register stage after the fold stage
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	output logic signed [Z_W-1:0]  z_out
);

	logic signed [XY_W-1:0] cx_s    [0:STAGES];
	logic signed [XY_W-1:0] cy_s    [0:STAGES];
	logic signed [Z_W-1:0]  cz_s    [0:STAGES];
	logic                   czero_s [0:STAGES];

	// left half plane fold
	always_ff @(posedge clk) begin
		if (en) begin
			czero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in[XY_W-1]) begin
				if (!y_in[XY_W-1]) begin
					cx_s[0] <= y_in;
					cy_s[0] <= -x_in;
					cz_s[0] <= HALF_PI_Q30;
				end else begin
					cx_s[0] <= -y_in;
					cy_s[0] <= x_in;
					cz_s[0] <= -HALF_PI_Q30;
				end
			end else begin
				cx_s[0] <= x_in;
				cy_s[0] <= y_in;
				cz_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= STAGES; k++) begin : g_iter
		localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TAB[k-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				czero_s[k] <= czero_s[k-1];
				if (!cy_s[k-1][XY_W-1]) begin
					cx_s[k] <= cx_s[k-1] + (cy_s[k-1] >>> (k-1));
					cy_s[k] <= cy_s[k-1] - (cx_s[k-1] >>> (k-1));
					cz_s[k] <= cz_s[k-1] + ANG;
				end else begin
					cx_s[k] <= cx_s[k-1] - (cy_s[k-1] >>> (k-1));
					cy_s[k] <= cy_s[k-1] + (cx_s[k-1] >>> (k-1));
					cz_s[k] <= cz_s[k-1] - ANG;
				end
			end
		end
	end

	assign z_out = czero_s[STAGES] ? '0 : cz_s[STAGES];

endmodule

FILE: rtl/core/quaternion_to_euler_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_core
// unit quaternion to z-y-x euler angles, fully pipelined
// an accepted item passes the product, sum, square, radicand, root and cordic stages, then the output register
// throughput: one item per cycle while the skid is empty, set by the unrolled sqrt and cordic stages
// a two-entry output skid keeps the pipe moving while a result waits
// reset clears all valid bits and the output and skid flags, data is left as is
// ----------------------------------------------------------------------------
module quaternion_to_euler_core import q2e_pkg::*; #(
	parameter int COMPONENT_BITS = 16,
	parameter int ANGLE_BITS     = 16,
	parameter int CORDIC_STAGES  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// quat_w, quat_x, quat_y, quat_z
	input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// roll_angle, pitch_angle, yaw_angle
	output logic [((3*ANGLE_BITS-1+7)/8)*8-1:0] m_axis_tdata,
	// pitch_clamped
	output logic m_axis_tuser
);

	localparam int CB     = COMPONENT_BITS;
	localparam int OUT_W  = ((3*ANGLE_BITS-1+7)/8)*8;
	localparam int F2     = 2*(CB-2);
	localparam int PSH_R  = (F2 >= FRAC_Q) ? F2 - FRAC_Q : 0;
	localparam int PSH_L  = (F2 <  FRAC_Q) ? FRAC_Q - F2 : 0;
	localparam int ANG_SH = FRAC_Q - (ANGLE_BITS - 3);
	localparam int NV     = 4 + SQRT_STEPS + CORDIC_STAGES + 1;
	localparam logic signed [Z_W-1:0] ROUND_BIAS = Z_W'(1) <<< (ANG_SH - 1);

	typedef struct packed {
		logic signed [XY_W-1:0] sinr;
		logic signed [XY_W-1:0] cosr;
		logic signed [XY_W-1:0] sinp;
		logic signed [XY_W-1:0] siny;
		logic signed [XY_W-1:0] cosy;
		logic                   clamp;
	} trig_t;

	typedef struct packed {
		logic clamp;
		logic pos;
	} pflag_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] roll;
		logic [ANGLE_BITS-2:0] pitch;
		logic [ANGLE_BITS-1:0] yaw;
		logic                  clamp;
	} res_t;

	function automatic logic signed [PROD_W-1:0] to_q30(input logic signed [2*CB-1:0] p);
		if (F2 >= FRAC_Q)
			return PROD_W'(p >>> PSH_R);
		else
			return PROD_W'(p) <<< PSH_L;
	endfunction

	function automatic logic signed [Z_W-1:0] round_q(input logic signed [Z_W-1:0] a,
			input logic signed [Z_W-1:0] lim);
		logic signed [Z_W-1:0] c;
		c = a;
		if (a > lim)
			c = lim;
		if (a < -lim)
			c = -lim;
		return (c + ROUND_BIAS) >>> ANG_SH;
	endfunction

	logic en;
	logic [NV-1:0] valid_s;

	logic signed [CB-1:0] qw, qx, qy, qz;
	assign qw = s_axis_tdata[CB-1:0];
	assign qx = s_axis_tdata[2*CB-1:CB];
	assign qy = s_axis_tdata[3*CB-1:2*CB];
	assign qz = s_axis_tdata[4*CB-1:3*CB];

	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[NV-2:0], s_axis_tvalid};
		end
	end

	// stage 1: component products
	logic signed [PROD_W-1:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wy_s1;
	logic signed [PROD_W-1:0] p_zx_s1, p_wz_s1, p_xy_s1, p_zz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= to_q30(qw * qx);
			p_yz_s1 <= to_q30(qy * qz);
			p_xx_s1 <= to_q30(qx * qx);
			p_yy_s1 <= to_q30(qy * qy);
			p_wy_s1 <= to_q30(qw * qy);
			p_zx_s1 <= to_q30(qz * qx);
			p_wz_s1 <= to_q30(qw * qz);
			p_xy_s1 <= to_q30(qx * qy);
			p_zz_s1 <= to_q30(qz * qz);
		end
	end

	// stage 2: product sums
	trig_t trig_s2;
	logic signed [XY_W-1:0] sinp_c;
	assign sinp_c = (XY_W'(p_wy_s1) - XY_W'(p_zx_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s2.sinr  <= (XY_W'(p_wx_s1) + XY_W'(p_yz_s1)) <<< 1;
			trig_s2.cosr  <= ONE_Q30 - ((XY_W'(p_xx_s1) + XY_W'(p_yy_s1)) <<< 1);
			trig_s2.sinp  <= sinp_c;
			trig_s2.siny  <= (XY_W'(p_wz_s1) + XY_W'(p_xy_s1)) <<< 1;
			trig_s2.cosy  <= ONE_Q30 - ((XY_W'(p_yy_s1) + XY_W'(p_zz_s1)) <<< 1);
			trig_s2.clamp <= (sinp_c >= ONE_Q30) || (sinp_c <= -ONE_Q30);
		end
	end

	// stage 3: square of the pitch sine
	logic signed [XY_W-1:0] sinp_abs;
	logic [MAG_W-1:0]       mag;
	logic [SQ_W-1:0]        sq_s3;
	trig_t                  trig_s3;

	assign sinp_abs = trig_s2.sinp[XY_W-1] ? -trig_s2.sinp : trig_s2.sinp;
	assign mag      = sinp_abs[MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= SQ_W'(mag) * SQ_W'(mag);
			trig_s3 <= trig_s2;
		end
	end

	// stage 4 onward: radicand and one root digit per stage
	logic [RAD_W-1:0] rad_s  [0:SQRT_STEPS];
	sqrt_acc_t        acc_s  [0:SQRT_STEPS];
	trig_t            trig_s [0:SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= (RAD_W'(1) << 60) - RAD_W'(sq_s3);
			acc_s[0]  <= '0;
			trig_s[0] <= trig_s3;
		end
	end

	for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j]  <= rad_s[j-1] << 2;
				acc_s[j]  <= sqrt_step(acc_s[j-1], rad_s[j-1][RAD_W-1:RAD_W-2]);
				trig_s[j] <= trig_s[j-1];
			end
		end
	end

	// cordic lanes
	trig_t                  tl;
	logic signed [XY_W-1:0] cos_p;
	logic signed [Z_W-1:0]  roll_z, pitch_z, yaw_z;

	assign tl    = trig_s[SQRT_STEPS];
	assign cos_p = XY_W'(acc_s[SQRT_STEPS].root);

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk  (clk),
		.en   (en),
		.x_in (tl.cosr),
		.y_in (tl.sinr),
		.z_out(roll_z)
	);

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk  (clk),
		.en   (en),
		.x_in (cos_p),
		.y_in (tl.sinp),
		.z_out(pitch_z)
	);

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk  (clk),
		.en   (en),
		.x_in (tl.cosy),
		.y_in (tl.siny),
		.z_out(yaw_z)
	);

	pflag_t flag_s [0:CORDIC_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s[0].clamp <= tl.clamp;
			flag_s[0].pos   <= !tl.sinp[XY_W-1];
		end
	end

	for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_flag
		always_ff @(posedge clk) begin
			if (en) begin
				flag_s[k] <= flag_s[k-1];
			end
		end
	end

	// rounding to the output format
	logic signed [Z_W-1:0] pitch_sel;
	logic signed [Z_W-1:0] roll_r, pitch_r, yaw_r;
	res_t                  res;

	always_comb begin
		if (flag_s[CORDIC_STAGES].clamp)
			pitch_sel = flag_s[CORDIC_STAGES].pos ? HALF_PI_Q30 : -HALF_PI_Q30;
		else
			pitch_sel = pitch_z;
	end

	assign roll_r    = round_q(roll_z, PI_Q30);
	assign pitch_r   = round_q(pitch_sel, HALF_PI_Q30);
	assign yaw_r     = round_q(yaw_z, PI_Q30);
	assign res.roll  = roll_r[ANGLE_BITS-1:0];
	assign res.pitch = pitch_r[ANGLE_BITS-2:0];
	assign res.yaw   = yaw_r[ANGLE_BITS-1:0];
	assign res.clamp = flag_s[CORDIC_STAGES].clamp;

	// output register with skid
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;
	logic last_v;

	assign last_v = valid_s[NV-1];
	assign en     = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (last_v) begin
				if (!out_v_q || m_axis_tready)
					out_v_q <= 1'b1;
				else
					skid_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end else if (m_axis_tready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (last_v) begin
				if (!out_v_q || m_axis_tready)
					out_q <= res;
				else
					skid_q <= res;
			end
		end else if (m_axis_tready) begin
			out_q <= skid_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OUT_W'({out_q.yaw, out_q.pitch, out_q.roll});
	assign m_axis_tuser  = out_q.clamp;

endmodule

FILE: sim/tb_quaternion_to_euler_core.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_core
// streams quaternions through the core under bursty input and stalled output,
// predicts roll, pitch, yaw and the clamp flag per item and checks each result
// in order against the oldest prediction
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_core;
	import q2e_pkg::*;

	typedef struct {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct {
		logic [15:0] roll;
		logic [14:0] pitch;
		logic [15:0] yaw;
		logic        clamp;
	} euler_t;

	class euler_scoreboard;
		euler_t angles_due[$];
		int     errors;

		function longint prod(longint a, longint b);
			return a * b * 4;
		endfunction

		function longint root_floor(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return longint'(r);
		endfunction

		function longint vec_angle(longint y, longint x);
			longint a;
			longint t;
			longint dx;
			longint dy;
			a = 0;
			if (x == 0 && y == 0) return 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; a = longint'(HALF_PI_Q30);
				end else begin
					t = x; x = -y; y = t; a = -longint'(HALF_PI_Q30);
				end
			end
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x = x + dx; y = y - dy; a = a + longint'(ATAN_TAB[i]);
				end else begin
					x = x - dx; y = y + dy; a = a - longint'(ATAN_TAB[i]);
				end
			end
			return a;
		endfunction

		function longint round_angle(longint a, longint lim);
			if (a > lim) a = lim;
			if (a < -lim) a = -lim;
			return (a + (64'sd1 << 16)) >>> 17;
		endfunction

		function void note_quat(quat_t q);
			longint w, x, y, z, one, sr, cr, sp, sy, cy, c, p;
			euler_t e;
			w = q.w; x = q.x; y = q.y; z = q.z;
			one = 64'sd1 << 30;
			sr = 2 * (prod(w, x) + prod(y, z));
			cr = one - 2 * (prod(x, x) + prod(y, y));
			sp = 2 * (prod(w, y) - prod(z, x));
			sy = 2 * (prod(w, z) + prod(x, y));
			cy = one - 2 * (prod(y, y) + prod(z, z));
			if (sp >= one || sp <= -one) begin
				p = sp > 0 ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
				e.clamp = 1'b1;
			end else begin
				c = root_floor((64'd1 << 60) - longint'(sp * sp));
				p = vec_angle(sp, c);
				e.clamp = 1'b0;
			end
			e.roll  = 16'(round_angle(vec_angle(sr, cr), longint'(PI_Q30)));
			e.pitch = 15'(round_angle(p, longint'(HALF_PI_Q30)));
			e.yaw   = 16'(round_angle(vec_angle(sy, cy), longint'(PI_Q30)));
			angles_due.push_back(e);
		endfunction

		function void check_angles(logic [47:0] d, logic u);
			euler_t e;
			if (angles_due.size() == 0) begin
				$display("%0t: unexpected item data %h tuser %b", $time, d, u);
				errors++;
				return;
			end
			e = angles_due.pop_front();
			if (d[15:0] !== e.roll) begin
				$display("%0t: roll expected %h actual %h", $time, e.roll, d[15:0]);
				errors++;
			end
			if (d[30:16] !== e.pitch) begin
				$display("%0t: pitch expected %h actual %h", $time, e.pitch, d[30:16]);
				errors++;
			end
			if (d[46:31] !== e.yaw) begin
				$display("%0t: yaw expected %h actual %h", $time, e.yaw, d[46:31]);
				errors++;
			end
			if (d[47] !== 1'b0) begin
				$display("%0t: pad expected 0 actual %b", $time, d[47]);
				errors++;
			end
			if (u !== e.clamp) begin
				$display("%0t: clamp expected %b actual %b", $time, e.clamp, u);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// quat_w, quat_x, quat_y, quat_z
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// roll_angle, pitch_angle, yaw_angle
	logic [47:0] m_axis_tdata;
	// pitch_clamped
	logic        m_axis_tuser;

	euler_scoreboard sb = new();
	int quiet_cycles = 0;
	int burst_left = 0;

	quaternion_to_euler_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_angles(m_axis_tdata, m_axis_tuser);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000) begin
			$display("tb_quaternion_to_euler_core: FAIL");
			$finish;
		end
	end

	// output stall pattern, with one long hold-off
	initial begin
		int mode;
		@(posedge arst_n);
		for (int c = 0; ; c++) begin
			@(negedge clk);
			if (c % 97 == 0) mode = $urandom_range(0, 3);
			if (c >= 300 && c < 700)
				m_axis_tready <= 1'b0;
			else
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 1);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (c % 5 != 0);
				endcase
		end
	end

	task automatic send_quat(quat_t q);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 6)) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {q.z, q.y, q.x, q.w};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_quat(q);
	endtask

	function automatic quat_t mk(int w, int x, int y, int z);
		quat_t q;
		q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
		return q;
	endfunction

	function automatic int rnd_comp();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic quat_t unit_quat();
		real c [4];
		real n;
		quat_t q;
		do begin
			n = 0.0;
			for (int i = 0; i < 4; i++) begin
				c[i] = rnd_comp();
				n = n + c[i] * c[i];
			end
		end while (n < 1.0e6);
		n = $sqrt(n);
		q = mk($rtoi(c[0] * 16384.0 / n), $rtoi(c[1] * 16384.0 / n),
			$rtoi(c[2] * 16384.0 / n), $rtoi(c[3] * 16384.0 / n));
		return q;
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.angles_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		quat_t q;
		int    k;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_quat(mk(16384, 0, 0, 0));
		send_quat(mk(-16384, 0, 0, 0));
		send_quat(mk(0, 0, 0, 0));
		send_quat(mk(0, 16384, 0, 0));
		send_quat(mk(0, 0, 16384, 0));
		send_quat(mk(0, 0, 0, 16384));
		send_quat(mk(0, 0, 0, -16384));
		send_quat(mk(11585, 0, 11585, 0));
		send_quat(mk(11586, 0, 11586, 0));
		send_quat(mk(11585, 0, -11586, 0));
		send_quat(mk(16384, 0, 16384, 0));
		send_quat(mk(16384, 0, -16384, 0));
		send_quat(mk(0, 16384, 0, 16384));
		send_quat(mk(16384, 16384, 16384, 16384));
		send_quat(mk(-16384, -16384, -16384, -16384));
		send_quat(mk(-16384, 16384, -16384, 16384));
		send_quat(mk(0, 16384, 1, 0));
		send_quat(mk(0, 16384, -1, 0));
		send_quat(mk(8192, 8192, 8192, -8192));
		send_quat(mk(1, -1, 1, -1));
		wait_drained();

		for (int i = 0; i < 1150; i++) begin
			k = $urandom_range(0, 9);
			if (k < 6) q = unit_quat();
			else if (k < 9) q = mk(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
			else q = mk($urandom_range(0, 1) ? 16384 : -16384, rnd_comp(),
				$urandom_range(0, 1) ? 16384 : -16384, rnd_comp());
			send_quat(q);
			if (i == 600) wait_drained();
		end
		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_quaternion_to_euler_core: PASS");
		else
			$display("tb_quaternion_to_euler_core: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/q2e_pkg.sv
rtl/core/q2e_cordic.sv
rtl/core/quaternion_to_euler_core.sv
sim/tb_quaternion_to_euler_core.sv
